/* design/mma_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mma_pkg
// Shared types and constants of the multichannel moving-average filter.
// ----------------------------------------------------------------------------
package mma_pkg;

    localparam int CHAN_W    = 3;
    localparam int SAMPLE_W  = 16;
    localparam int NUM_REGS  = 5;
    localparam int REG_W     = 6;
    localparam int CFG_IDX_W = 3;
    localparam logic [REG_W-1:0] REG_RESET = 6'd16;

    typedef struct packed {
        logic clr;
        logic load;
        logic rd;
        logic upd;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic clr_done;
        logic chan_ok;
        logic div_done;
        logic out_free;
    } t_status;

endpackage
`default_nettype wire

/* design/mma_ram.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mma_ram
// Generic simple dual-port RAM with one write port and a registered read port.
// ----------------------------------------------------------------------------
module mma_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 160,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

/* design/mma_div.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mma_div
// Radix-2 restoring divider that produces one quotient bit per cycle.
// ----------------------------------------------------------------------------
module mma_div #(
    parameter int DW = 21,
    parameter int VW = 6
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_start,
    input  wire logic [DW-1:0] i_dividend,
    input  wire logic [VW-1:0] i_divisor,
    output logic               o_done,
    output logic      [DW-1:0] o_quotient
);

    localparam int CW = $clog2(DW);

    logic [DW-1:0] r_quo;
    logic [VW-1:0] r_rem;
    logic [VW-1:0] r_div;
    logic [CW-1:0] r_cnt;
    logic          r_busy;
    logic          r_done;
    logic [VW:0]   w_trial;
    logic          w_fit;

    assign w_trial = {r_rem, r_quo[DW-1]};
    assign w_fit   = (w_trial >= {1'b0, r_div});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + 1'b1;
            if (r_cnt == CW'(DW - 1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[DW-2:0], w_fit};
            r_rem <= w_fit ? VW'(w_trial - {1'b0, r_div}) : w_trial[VW-1:0];
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule
`default_nettype wire

/* design/mma_dp.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mma_dp
// Datapath: window store, per-channel sums and positions, window-length
// registers, divider and the output register.
// ----------------------------------------------------------------------------
module mma_dp
    import mma_pkg::*;
#(
    parameter int NUM_CHANNELS = 5,
    parameter int MAX_WINDOW   = 32
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire t_cmd                 i_cmd,
    output t_status                   o_status,
    input  wire logic [CHAN_W-1:0]    i_chan,
    input  wire logic [SAMPLE_W-1:0]  i_sample,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [REG_W-1:0]     i_cfg_data,
    output logic                      o_out_valid,
    input  wire logic                 i_out_ready,
    output logic      [CHAN_W-1:0]    o_out_chan,
    output logic      [SAMPLE_W-1:0]  o_out_avg
);

    localparam int DEPTH = NUM_CHANNELS * MAX_WINDOW;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int PW    = $clog2(MAX_WINDOW);
    localparam int LW    = $clog2(MAX_WINDOW + 1);
    localparam int SW    = SAMPLE_W + PW;
    localparam int CIW   = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

    logic [REG_W-1:0]    r_win_len [NUM_REGS];
    logic [SW-1:0]       r_sum     [NUM_CHANNELS];
    logic [PW-1:0]       r_wpos    [NUM_CHANNELS];
    logic                r_filled  [NUM_CHANNELS];
    logic [AW-1:0]       r_clr_addr;
    logic [CHAN_W-1:0]   r_chan;
    logic [SAMPLE_W-1:0] r_sample;
    logic                r_out_valid;
    logic [CHAN_W-1:0]   r_out_chan;
    logic [SAMPLE_W-1:0] r_out_avg;

    logic [CIW-1:0]      w_ci;
    logic                w_chan_ok;
    logic [REG_W-1:0]    w_raw_len;
    logic [LW-1:0]       w_len;
    logic [PW-1:0]       w_pos;
    logic [LW-1:0]       w_pos_next;
    logic [AW-1:0]       w_addr;
    logic [SAMPLE_W-1:0] w_old;
    logic [SW-1:0]       w_new_sum;
    logic [LW-1:0]       w_divisor;
    logic                w_div_done;
    logic [SW-1:0]       w_quo;
    logic [SAMPLE_W-1:0] w_avg;
    logic                w_we;
    logic [AW-1:0]       w_waddr;
    logic [SAMPLE_W-1:0] w_wdata;

    assign w_ci      = CIW'(r_chan);
    assign w_chan_ok = (32'(r_chan) < NUM_CHANNELS);

    always_comb begin
        w_raw_len = REG_W'(1);
        if (32'(r_chan) < NUM_REGS) begin
            w_raw_len = r_win_len[r_chan];
        end
        if (w_raw_len == '0) begin
            w_len = LW'(1);
        end else if (32'(w_raw_len) > MAX_WINDOW) begin
            w_len = LW'(MAX_WINDOW);
        end else begin
            w_len = LW'(w_raw_len);
        end
    end

    assign w_pos      = (32'(r_wpos[w_ci]) >= 32'(w_len)) ? '0 : r_wpos[w_ci];
    assign w_pos_next = LW'(w_pos) + LW'(1);
    assign w_addr     = AW'(32'(w_ci) * MAX_WINDOW + 32'(w_pos));
    assign w_new_sum  = r_sum[w_ci] - SW'(w_old) + SW'(r_sample);

    always_comb begin
        if (w_pos_next == w_len || r_filled[w_ci]) begin
            w_divisor = w_len;
        end else begin
            w_divisor = w_pos_next;
        end
    end

    assign w_we    = i_cmd.clr | i_cmd.upd;
    assign w_waddr = i_cmd.clr ? r_clr_addr : w_addr;
    assign w_wdata = i_cmd.clr ? '0 : r_sample;

    mma_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (i_cmd.rd),
        .i_raddr (w_addr),
        .o_rdata (w_old)
    );

    mma_div #(
        .DW (SW),
        .VW (LW)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.upd),
        .i_dividend (w_new_sum),
        .i_divisor  (w_divisor),
        .o_done     (w_div_done),
        .o_quotient (w_quo)
    );

    assign w_avg = (|w_quo[SW-1:SAMPLE_W]) ? '1 : w_quo[SAMPLE_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_REGS; i++) begin
                r_win_len[i] <= REG_RESET;
            end
        end else if (i_cfg_we && (32'(i_cfg_index) < NUM_REGS)) begin
            r_win_len[i_cfg_index] <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr <= '0;
        end else if (i_cmd.clr) begin
            r_clr_addr <= r_clr_addr + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_CHANNELS; i++) begin
                r_sum[i]    <= '0;
                r_wpos[i]   <= '0;
                r_filled[i] <= 1'b0;
            end
        end else if (i_cmd.upd) begin
            r_sum[w_ci] <= w_new_sum;
            if (w_pos_next == w_len) begin
                r_wpos[w_ci]   <= '0;
                r_filled[w_ci] <= 1'b1;
            end else begin
                r_wpos[w_ci] <= PW'(w_pos_next);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_chan   <= i_chan;
            r_sample <= i_sample;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_chan <= r_chan;
            r_out_avg  <= w_chan_ok ? w_avg : '0;
        end
    end

    assign o_status.clr_done = (r_clr_addr == AW'(DEPTH - 1));
    assign o_status.chan_ok  = w_chan_ok;
    assign o_status.div_done = w_div_done;
    assign o_status.out_free = !r_out_valid || i_out_ready;

    assign o_out_valid = r_out_valid;
    assign o_out_chan  = r_out_chan;
    assign o_out_avg   = r_out_avg;

endmodule
`default_nettype wire

/* design/mma_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mma_ctrl
// Controller: sequences the store clear, read, update, divide and output.
// ----------------------------------------------------------------------------
module mma_ctrl
    import mma_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_in_valid,
    output logic         o_in_ready,
    input  wire t_status i_status,
    output t_cmd         o_cmd
);

    localparam logic [2:0] S_CLEAR  = 3'd0;
    localparam logic [2:0] S_IDLE   = 3'd1;
    localparam logic [2:0] S_READ   = 3'd2;
    localparam logic [2:0] S_UPDATE = 3'd3;
    localparam logic [2:0] S_DIV    = 3'd4;
    localparam logic [2:0] S_DONE   = 3'd5;

    logic [2:0] r_state;
    logic [2:0] n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.clr = 1'b1;
                if (i_status.clr_done) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_READ;
                end
            end
            S_READ: begin
                if (i_status.chan_ok) begin
                    o_cmd.rd = 1'b1;
                    n_state  = S_UPDATE;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_UPDATE: begin
                o_cmd.upd = 1'b1;
                n_state   = S_DIV;
            end
            S_DIV: begin
                if (i_status.div_done) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (i_status.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

/* design/multichannel_moving_average.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// multichannel_moving_average
// Per-channel boxcar moving average with running sums and a shared divider.
//
// Channel   Direction  Handshake                  Payload
// s_axis    in         i_s_axis_tvalid/o_..tready tuser = chan, tdata = sample
// m_axis    out        o_m_axis_tvalid/i_..tready tuser = out_chan, tdata = average
// cfg       in         i_cfg_valid/o_cfg_ready    index = register, data = length
//
// A new input is taken only after the previous one is divided and loaded into
// the output register; the bit-serial divider makes one quotient bit per cycle.
// After reset the whole window store is cleared before the first input
// transaction is taken; configuration is taken always.
// A finished result waits in the output register while the next one is in work.
// ----------------------------------------------------------------------------
module multichannel_moving_average
    import mma_pkg::*;
#(
    parameter int NUM_CHANNELS = 5,
    parameter int MAX_WINDOW   = 32
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_s_axis_tvalid,
    output logic                      o_s_axis_tready,
    input  wire logic [15:0]          i_s_axis_tdata,  // [15:0] sample
    input  wire logic [CHAN_W-1:0]    i_s_axis_tuser,  // [2:0] chan
    output logic                      o_m_axis_tvalid,
    input  wire logic                 i_m_axis_tready,
    output logic      [15:0]          o_m_axis_tdata,  // [15:0] average
    output logic      [CHAN_W-1:0]    o_m_axis_tuser,  // [2:0] out_chan
    input  wire logic                 i_cfg_valid,
    output logic                      o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [REG_W-1:0]     i_cfg_data
);

    t_cmd    w_cmd;
    t_status w_status;

    assign o_cfg_ready = 1'b1;

    mma_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_axis_tvalid),
        .o_in_ready (o_s_axis_tready),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    mma_dp #(
        .NUM_CHANNELS (NUM_CHANNELS),
        .MAX_WINDOW   (MAX_WINDOW)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_status    (w_status),
        .i_chan      (i_s_axis_tuser),
        .i_sample    (i_s_axis_tdata),
        .i_cfg_we    (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_out_valid (o_m_axis_tvalid),
        .i_out_ready (i_m_axis_tready),
        .o_out_chan  (o_m_axis_tuser),
        .o_out_avg   (o_m_axis_tdata)
    );

endmodule
`default_nettype wire

/* verif/multichannel_moving_average_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multichannel_moving_average_test
// Self-checking testbench for the multichannel moving-average filter. A local
// model of the per-channel running sums predicts each average. Directed
// samples cover the extremes and the window corner cases, and several random
// phases with fresh window lengths follow. Both stream sides idle at random,
// and the output side holds off for a long stretch once.
// ----------------------------------------------------------------------------
module multichannel_moving_average_test;
    import mma_pkg::*;

    localparam int NUM_CHANNELS = 5;
    localparam int MAX_WINDOW   = 32;
    localparam int STALL_LIMIT  = 4000;
    localparam int SETTLE_CYCLES = 60;

    typedef enum logic [CFG_IDX_W-1:0] {
        WIN_LEN_CH0 = 3'd0,
        WIN_LEN_CH1 = 3'd1,
        WIN_LEN_CH2 = 3'd2,
        WIN_LEN_CH3 = 3'd3,
        WIN_LEN_CH4 = 3'd4,
        WIN_LEN_NONE = 3'd7
    } t_reg_idx;

    typedef struct packed {
        logic [CHAN_W-1:0]   chan;
        logic [SAMPLE_W-1:0] average;
    } t_avg_result;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 i_s_axis_tvalid;
    logic                 o_s_axis_tready;
    logic [15:0]          i_s_axis_tdata;
    logic [CHAN_W-1:0]    i_s_axis_tuser;
    logic                 o_m_axis_tvalid;
    logic                 i_m_axis_tready;
    logic [15:0]          o_m_axis_tdata;
    logic [CHAN_W-1:0]    o_m_axis_tuser;
    logic                 i_cfg_valid;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [REG_W-1:0]     i_cfg_data;

    logic [REG_W-1:0]    win_len [NUM_REGS];
    logic [SAMPLE_W-1:0] taps [NUM_CHANNELS][MAX_WINDOW];
    logic [20:0]         run_sum [NUM_CHANNELS];
    int                  wr_pos [NUM_CHANNELS];
    logic                filled [NUM_CHANNELS];

    t_avg_result pending_averages[$];
    int          mismatch_count = 0;
    int          holdoff_left = 0;
    bit          quiet = 1'b0;
    int          stall_cycles = 0;

    multichannel_moving_average #(
        .NUM_CHANNELS(NUM_CHANNELS),
        .MAX_WINDOW  (MAX_WINDOW)
    ) uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_s_axis_tvalid(i_s_axis_tvalid),
        .o_s_axis_tready(o_s_axis_tready),
        .i_s_axis_tdata (i_s_axis_tdata),
        .i_s_axis_tuser (i_s_axis_tuser),
        .o_m_axis_tvalid(o_m_axis_tvalid),
        .i_m_axis_tready(i_m_axis_tready),
        .o_m_axis_tdata (o_m_axis_tdata),
        .o_m_axis_tuser (o_m_axis_tuser),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    always #10 i_clk = ~i_clk;

    function automatic logic [SAMPLE_W-1:0] predict_average(
        input logic [CHAN_W-1:0] ch, input logic [SAMPLE_W-1:0] smp);
        int          len;
        int          p;
        int          divisor;
        logic [31:0] quotient;
        if (ch >= NUM_CHANNELS) begin
            return '0;
        end
        len = win_len[ch];
        if (len == 0) begin
            len = 1;
        end
        if (len > MAX_WINDOW) begin
            len = MAX_WINDOW;
        end
        p = wr_pos[ch];
        if (p >= len) begin
            p = 0;
        end
        run_sum[ch] = run_sum[ch] - taps[ch][p] + smp;
        taps[ch][p] = smp;
        p++;
        if (p == len) begin
            p = 0;
            filled[ch] = 1'b1;
        end
        wr_pos[ch] = p;
        divisor = filled[ch] ? len : p;
        if (divisor == 0) begin
            divisor = 1;
        end
        quotient = 32'(run_sum[ch]) / divisor;
        if (quotient > 32'hFFFF) begin
            quotient = 32'hFFFF;
        end
        return quotient[SAMPLE_W-1:0];
    endfunction

    task automatic send_sample(input logic [CHAN_W-1:0] ch, input logic [SAMPLE_W-1:0] smp);
        t_avg_result due;
        @(negedge i_clk);
        if (!quiet) begin
            while ($urandom_range(0, 99) < 14) begin
                i_s_axis_tvalid = 1'b0;
                @(negedge i_clk);
            end
        end
        i_s_axis_tvalid = 1'b1;
        i_s_axis_tuser  = ch;
        i_s_axis_tdata  = smp;
        do @(posedge i_clk); while (!o_s_axis_tready);
        due.chan    = ch;
        due.average = predict_average(ch, smp);
        pending_averages.push_back(due);
    endtask

    task automatic wait_for_drain();
        @(negedge i_clk);
        i_s_axis_tvalid = 1'b0;
        while (pending_averages.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    task automatic write_window_len(input t_reg_idx idx, input logic [REG_W-1:0] len);
        @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = len;
        do @(posedge i_clk); while (!o_cfg_ready);
        if (idx < NUM_REGS) begin
            win_len[idx] = len;
        end
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    function automatic logic [CHAN_W-1:0] random_chan();
        if ($urandom_range(0, 9) == 0) begin
            return CHAN_W'($urandom_range(NUM_CHANNELS, 7));
        end
        return CHAN_W'($urandom_range(0, NUM_CHANNELS - 1));
    endfunction

    function automatic logic [SAMPLE_W-1:0] random_sample();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return '1;
            default: return SAMPLE_W'($urandom);
        endcase
    endfunction

    function automatic logic [REG_W-1:0] random_len();
        case ($urandom_range(0, 13))
            0: return 6'd0;
            1: return 6'd1;
            2: return 6'd2;
            3: return 6'd31;
            4: return 6'd32;
            5: return 6'd33;
            6: return 6'd63;
            default: return REG_W'($urandom_range(0, 63));
        endcase
    endfunction

    task automatic test_reset_extremes();
        send_sample(3'd0, 16'hFFFF);
        send_sample(3'd0, 16'h0000);
        send_sample(3'd4, 16'hFFFF);
        send_sample(3'd5, 16'h1234);
        send_sample(3'd7, 16'hFFFF);
        send_sample(3'd6, 16'hAAAA);
        send_sample(3'd2, 16'h5555);
        send_sample(3'd3, 16'h8001);
    endtask

    task automatic test_window_limits();
        wait_for_drain();
        write_window_len(WIN_LEN_CH0, 6'd1);
        write_window_len(WIN_LEN_CH1, 6'd0);
        write_window_len(WIN_LEN_CH2, 6'd63);
        write_window_len(WIN_LEN_CH3, 6'd32);
        write_window_len(WIN_LEN_CH4, 6'd2);
        write_window_len(WIN_LEN_NONE, 6'd5);
        send_sample(3'd1, 16'h00FF);
        send_sample(3'd1, 16'hFF00);
        send_sample(3'd0, 16'hFFFF);
        send_sample(3'd0, 16'h0001);
        send_sample(3'd4, 16'hFFFF);
        send_sample(3'd4, 16'hFFFE);
        send_sample(3'd4, 16'h0003);
    endtask

    task automatic test_shrink_window();
        repeat (6) begin
            send_sample(3'd2, 16'hFFFF);
        end
        wait_for_drain();
        write_window_len(WIN_LEN_CH2, 6'd2);
        write_window_len(WIN_LEN_CH4, 6'd5);
        send_sample(3'd2, 16'hFFFF);
        send_sample(3'd4, 16'h7FFF);
    endtask

    task automatic test_output_holdoff();
        wait_for_drain();
        holdoff_left = 300;
        repeat (30) begin
            send_sample(random_chan(), random_sample());
        end
    endtask

    task automatic test_random_phases();
        for (int phase = 0; phase < 6; phase++) begin
            wait_for_drain();
            for (int c = 0; c < NUM_REGS; c++) begin
                write_window_len(t_reg_idx'(c), random_len());
            end
            quiet = (phase == 2);
            repeat (95) begin
                send_sample(random_chan(), random_sample());
            end
            quiet = 1'b0;
        end
    endtask

    always @(negedge i_clk) begin
        if (holdoff_left > 0) begin
            holdoff_left--;
            i_m_axis_tready = 1'b0;
        end else if (quiet || !i_rst_n) begin
            i_m_axis_tready = i_rst_n;
        end else begin
            i_m_axis_tready = ($urandom_range(0, 99) >= 14);
        end
    end

    always @(posedge i_clk) begin
        t_avg_result due;
        if (o_m_axis_tvalid && i_m_axis_tready) begin
            if (pending_averages.size() == 0) begin
                $error("out_chan: expected no transaction, actual %0d", o_m_axis_tuser);
                mismatch_count++;
            end else begin
                due = pending_averages.pop_front();
                if (o_m_axis_tuser !== due.chan) begin
                    $error("out_chan: expected %0d, actual %0d", due.chan, o_m_axis_tuser);
                    mismatch_count++;
                end
                if (o_m_axis_tdata !== due.average) begin
                    $error("average: expected %0d, actual %0d", due.average, o_m_axis_tdata);
                    mismatch_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_s_axis_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && i_m_axis_tready)
                || (i_cfg_valid && o_cfg_ready)) begin
            stall_cycles = 0;
        end else begin
            stall_cycles++;
        end
        if (stall_cycles >= STALL_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    initial begin
        i_rst_n         = 1'b0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata  = '0;
        i_s_axis_tuser  = '0;
        i_m_axis_tready = 1'b0;
        i_cfg_valid     = 1'b0;
        i_cfg_index     = '0;
        i_cfg_data      = '0;
        for (int c = 0; c < NUM_CHANNELS; c++) begin
            run_sum[c] = '0;
            wr_pos[c]  = 0;
            filled[c]  = 1'b0;
            for (int k = 0; k < MAX_WINDOW; k++) begin
                taps[c][k] = '0;
            end
        end
        for (int r = 0; r < NUM_REGS; r++) begin
            win_len[r] = REG_RESET;
        end
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_reset_extremes();
        test_window_limits();
        test_shrink_window();
        test_output_holdoff();
        test_random_phases();

        wait_for_drain();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
